/* rtl/core/assert_macros.svh */
// Assertion macros shared by the z-buffer RTL.
// No dependencies; the macros are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ZB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("zbuffer assertion failed");
// condition must never be true outside reset
`define ZB_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("zbuffer forbidden condition seen");
`else
`define ZB_ASSERT(label, clk, rst, prop)
`define ZB_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* rtl/core/zb_pkg.sv */
// Types and constants of the pinhole point z-buffer.
// No dependencies.
`default_nettype none
package zb_pkg;
   // limit values in use, wide enough for a limit of 4096
   localparam int LIM_W = 13;
   // quotient bits of one projected coordinate (below 4096)
   localparam int QW = 12;
   // memory word: occupied flag, depth, three normals
   localparam int DEPTH_W = 31;
   localparam int NORM_W = 16;
   localparam int WORD_W = 1 + DEPTH_W + 3 * NORM_W;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_POINT = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_CLEARED    = 3'd0,
      STAT_REJECTED   = 3'd1,
      STAT_WRITTEN    = 3'd2,
      STAT_OCCLUDED   = 3'd3,
      STAT_READ_EMPTY = 3'd4,
      STAT_READ_HIT   = 3'd5
   } status_type;

   // register indexes of the csr port
   localparam logic [2:0] CSR_FOCAL_X  = 3'd0;
   localparam logic [2:0] CSR_FOCAL_Y  = 3'd1;
   localparam logic [2:0] CSR_CENTER_X = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y = 3'd3;
   localparam logic [2:0] CSR_ROWS     = 3'd4;
   localparam logic [2:0] CSR_COLS     = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PROJ,
      ST_LOOK
   } state_type;

   typedef enum logic [1:0] {
      P_IDLE,
      P_MUL,
      P_CHECK,
      P_DIV
   } proj_state_type;

   // camera setup as seen by the projection unit
   typedef struct packed {
      logic [27:0]      focal_x;
      logic [27:0]      focal_y;
      logic [25:0]      center_x;
      logic [25:0]      center_y;
      logic [LIM_W-1:0] rows;
      logic [LIM_W-1:0] cols;
   } proj_cfg_type;

   // projection outcome, done pulses for one cycle
   typedef struct packed {
      logic          done;
      logic          reject;
      logic [QW-1:0] row;
      logic [QW-1:0] col;
   } proj_res_type;
endpackage
`default_nettype wire

/* rtl/core/zb_mem.sv */
// Pixel store: one write port, one read port with registered data.
// Depends on zb_pkg for the word width.
`default_nettype none
module zb_mem
   import zb_pkg::*;
#(
   parameter int DEPTH = 524288,
   parameter int AW = 19
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [AW-1:0]     waddr,
   input  wire logic [WORD_W-1:0] wdata,
   input  wire logic [AW-1:0]     raddr,
   output logic      [WORD_W-1:0] rdata
);
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* rtl/core/zb_proj.sv */
// Projection unit: per axis three products, a range check and a
// restoring division by z, one quotient bit a cycle. Depends on zb_pkg.
`default_nettype none
module zb_proj
   import zb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic signed [31:0]  point_x,
   input  wire logic signed [31:0]  point_y,
   input  wire logic signed [31:0]  point_z,
   input  wire proj_cfg_type        cfg,
   output proj_res_type             res
);
   proj_state_type       state_ff, state_in;
   logic                 axis_ff, axis_in;
   logic signed [60:0]   fp_ff, fp_in;
   logic [56:0]          cz_ff, cz_in;
   logic [43:0]          lz_ff, lz_in;
   logic [43:0]          rem_ff, rem_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [3:0]           bit_ff, bit_in;
   logic [QW-1:0]        col_ff, col_in;
   proj_res_type         res_ff, res_in;

   logic [27:0]          f_sel;
   logic [25:0]          c_sel;
   logic signed [31:0]   p_sel;
   logic [LIM_W-1:0]     lim_sel;
   logic signed [61:0]   num;
   logic signed [61:0]   bound;
   logic [44:0]          trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      fp_ff   <= fp_in;
      cz_ff   <= cz_in;
      lz_ff   <= lz_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bit_ff  <= bit_in;
      col_ff  <= col_in;
   end

   // axis operands: x feeds the column, y the row
   always_comb begin
      f_sel   = axis_ff ? cfg.focal_y : cfg.focal_x;
      c_sel   = axis_ff ? cfg.center_y : cfg.center_x;
      p_sel   = axis_ff ? point_y : point_x;
      lim_sel = axis_ff ? cfg.rows : cfg.cols;
   end

   // numerator and the upper bound lim * z * 2^16
   assign num   = $signed({fp_ff[60], fp_ff}) + $signed({5'b0, cz_ff});
   assign bound = $signed({2'b0, lz_ff, 16'b0});
   assign trial = {1'b0, rem_ff} - ({14'b0, point_z[30:0]} << bit_ff);

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      fp_in    = fp_ff;
      cz_in    = cz_ff;
      lz_in    = lz_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      col_in   = col_ff;
      res_in   = '0;
      res_in.row = res_ff.row;
      res_in.col = res_ff.col;
      case (state_ff)
         P_IDLE: begin
            if (start) begin
               axis_in = 1'b0;
               if (point_z <= 32'sd0) begin
                  res_in.done   = 1'b1;
                  res_in.reject = 1'b1;
               end else begin
                  state_in = P_MUL;
               end
            end
         end
         P_MUL: begin
            fp_in    = $signed({1'b0, f_sel}) * p_sel;
            cz_in    = c_sel * point_z[30:0];
            lz_in    = lim_sel * point_z[30:0];
            state_in = P_CHECK;
         end
         P_CHECK: begin
            if (num <= 62'sd0 || num >= bound) begin
               res_in.done   = 1'b1;
               res_in.reject = 1'b1;
               state_in      = P_IDLE;
            end else begin
               rem_in   = num[59:16];
               quo_in   = '0;
               bit_in   = 4'(QW - 1);
               state_in = P_DIV;
            end
         end
         P_DIV: begin
            if (!trial[44]) begin
               rem_in         = trial[43:0];
               quo_in[bit_ff] = 1'b1;
            end
            if (bit_ff == 4'd0) begin
               if (!axis_ff) begin
                  col_in   = quo_in;
                  axis_in  = 1'b1;
                  state_in = P_MUL;
               end else begin
                  res_in.done = 1'b1;
                  res_in.row  = quo_in;
                  res_in.col  = col_ff;
                  state_in    = P_IDLE;
               end
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end
         default: state_in = P_IDLE;
      endcase
   end

   assign res = res_ff;
endmodule
`default_nettype wire

/* rtl/core/pinhole_point_zbuffer.sv */
// Top level of the pinhole point z-buffer: command sequencer, settings,
// clearing pass and result register. Depends on zb_pkg, zb_proj, zb_mem, assert_macros.svh.
//
// channel  | ports                          | handshake
// request  | start, busy, req_*             | taken when start & !busy
// result   | rsp_valid, rsp_*               | one-cycle strobe, no back-pressure
// settings | csr_we, csr_index, csr_wdata   | written when csr_we is high
//
// Steps of a point command: start, per axis multiply, range check, QW=12
// divide steps, then read and compare/write; it is rejected by depth, by
// column or by row. A read in range looks up the memory; a read outside the
// limits or an unused command answers from idle; clear writes every word.
// After reset a clearing pass over ROW_LIMIT*COL_LIMIT words runs with busy high.
// A result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none
`include "assert_macros.svh"
module pinhole_point_zbuffer
   import zb_pkg::*;
#(
   parameter int ROW_LIMIT = 512,
   parameter int COL_LIMIT = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_command,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   input  wire logic signed [15:0] req_normal_in_x,
   input  wire logic signed [15:0] req_normal_in_y,
   input  wire logic signed [15:0] req_normal_in_z,
   input  wire logic [8:0]         req_read_row,
   input  wire logic [9:0]         req_read_col,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [30:0]             rsp_depth_out,
   output logic signed [15:0]      rsp_normal_out_x,
   output logic signed [15:0]      rsp_normal_out_y,
   output logic signed [15:0]      rsp_normal_out_z,
   output logic [8:0]              rsp_hit_row,
   output logic [9:0]              rsp_hit_col,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [27:0]        csr_wdata
);
   localparam int DEPTH = ROW_LIMIT * COL_LIMIT;
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] COLS_A = AW'(COL_LIMIT);
   localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
   localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(ROW_LIMIT);
   localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(COL_LIMIT);

   // settings
   logic [27:0] focal_x_ff, focal_y_ff;
   logic [25:0] center_x_ff, center_y_ff;
   logic [9:0]  rows_ff;
   logic [10:0] cols_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic               is_read_ff, is_read_in;
   logic               proj_go_ff, proj_go_in;
   logic [QW-1:0]      row_ff, row_in;
   logic [QW-1:0]      col_ff, col_in;

   // latched request beat
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [30:0]        rsp_depth_ff, rsp_depth_in;
   logic signed [15:0] rsp_nx_ff, rsp_nx_in, rsp_ny_ff, rsp_ny_in, rsp_nz_ff, rsp_nz_in;
   logic [8:0]         rsp_row_ff, rsp_row_in;
   logic [9:0]         rsp_col_ff, rsp_col_in;
   logic               rsp_no_hit;

   // memory side
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [WORD_W-1:0]  mem_wdata, mem_rdata;
   logic [AW-1:0]      pix_addr;
   logic               rd_in_range;

   proj_cfg_type       pcfg;
   proj_res_type       pres;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 28'd34406400;
         focal_y_ff  <= 28'd34406400;
         center_x_ff <= 26'd20971520;
         center_y_ff <= 26'd15728640;
         rows_ff     <= 10'd480;
         cols_ff     <= 11'd640;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FOCAL_X:  focal_x_ff  <= csr_wdata;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_wdata;
            CSR_CENTER_X: center_x_ff <= csr_wdata[25:0];
            CSR_CENTER_Y: center_y_ff <= csr_wdata[25:0];
            CSR_ROWS:     rows_ff     <= csr_wdata[9:0];
            CSR_COLS:     cols_ff     <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // effective image size, capped at the buffer limits
   always_comb begin
      pcfg.focal_x  = focal_x_ff;
      pcfg.focal_y  = focal_y_ff;
      pcfg.center_x = center_x_ff;
      pcfg.center_y = center_y_ff;
      pcfg.rows = (LIM_W'(rows_ff) > ROW_LIM) ? ROW_LIM : LIM_W'(rows_ff);
      pcfg.cols = (LIM_W'(cols_ff) > COL_LIM) ? COL_LIM : LIM_W'(cols_ff);
   end

   zb_proj u_proj (
      .clock   (clock),
      .reset   (reset),
      .start   (proj_go_ff),
      .point_x (x_ff),
      .point_y (y_ff),
      .point_z (z_ff),
      .cfg     (pcfg),
      .res     (pres)
   );

   zb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rd_in_range = (LIM_W'(req_read_row) < ROW_LIM) && (LIM_W'(req_read_col) < COL_LIM);
   assign pix_addr    = AW'(row_ff) * COLS_A + AW'(col_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         proj_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         proj_go_ff   <= proj_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_read_ff    <= is_read_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_nx_ff     <= rsp_nx_in;
      rsp_ny_ff     <= rsp_ny_in;
      rsp_nz_ff     <= rsp_nz_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      if (start && !busy) begin
         x_ff  <= req_point_x;
         y_ff  <= req_point_y;
         z_ff  <= req_point_z;
         nx_ff <= req_normal_in_x;
         ny_ff <= req_normal_in_y;
         nz_ff <= req_normal_in_z;
      end
   end

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      is_read_in    = is_read_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      proj_go_in    = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_nx_in     = rsp_nx_ff;
      rsp_ny_in     = rsp_ny_ff;
      rsp_nz_in     = rsp_nz_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      mem_we        = 1'b0;
      mem_waddr     = pix_addr;
      mem_wdata     = {1'b1, z_ff[30:0], nx_ff, ny_ff, nz_ff};
      mem_raddr     = pix_addr;

      // in every state: clear every field but the status, the state fills what applies
      if (state_ff == ST_IDLE || state_ff == ST_CLEAR ||
          state_ff == ST_PROJ || state_ff == ST_LOOK) begin
         rsp_depth_in = '0;
         rsp_nx_in    = '0;
         rsp_ny_in    = '0;
         rsp_nz_in    = '0;
         rsp_row_in   = '0;
         rsp_col_in   = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            mem_raddr = AW'(req_read_row) * COLS_A + AW'(req_read_col);
            if (start) begin
               case (cmd_type'(req_command))
                  CMD_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  CMD_POINT: begin
                     proj_go_in = 1'b1;
                     is_read_in = 1'b0;
                     state_in   = ST_PROJ;
                  end
                  CMD_READ: begin
                     if (rd_in_range) begin
                        is_read_in = 1'b1;
                        state_in   = ST_LOOK;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_READ_EMPTY;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_REJECTED;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_A) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_CLEARED;
               end
            end
         end
         ST_PROJ: begin
            mem_raddr = AW'(pres.row) * COLS_A + AW'(pres.col);
            if (pres.done) begin
               if (pres.reject) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_REJECTED;
                  state_in      = ST_IDLE;
               end else begin
                  row_in   = pres.row;
                  col_in   = pres.col;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (is_read_ff) begin
               if (mem_rdata[WORD_W-1]) begin
                  rsp_status_in = STAT_READ_HIT;
                  rsp_depth_in  = mem_rdata[WORD_W-2 -: DEPTH_W];
                  rsp_nx_in     = mem_rdata[3*NORM_W-1 -: NORM_W];
                  rsp_ny_in     = mem_rdata[2*NORM_W-1 -: NORM_W];
                  rsp_nz_in     = mem_rdata[NORM_W-1:0];
               end else begin
                  rsp_status_in = STAT_READ_EMPTY;
               end
            end else begin
               rsp_row_in = row_ff[8:0];
               rsp_col_in = col_ff[9:0];
               // ties keep the stored entry
               if (!mem_rdata[WORD_W-1] ||
                   (mem_rdata[WORD_W-2 -: DEPTH_W] > z_ff[30:0])) begin
                  mem_we        = 1'b1;
                  rsp_status_in = STAT_WRITTEN;
               end else begin
                  rsp_status_in = STAT_OCCLUDED;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_depth_out    = rsp_depth_ff;
   assign rsp_normal_out_x = rsp_nx_ff;
   assign rsp_normal_out_y = rsp_ny_ff;
   assign rsp_normal_out_z = rsp_nz_ff;
   assign rsp_hit_row      = rsp_row_ff;
   assign rsp_hit_col      = rsp_col_ff;

   // result beat that carries no stored pixel
   assign rsp_no_hit = rsp_valid_ff && (rsp_status_ff != STAT_READ_HIT);

   // checks
   `ZB_ASSERT(a_clear_busy, clock, reset, (state_ff == ST_CLEAR) |-> busy)
   `ZB_ASSERT(a_depth_only_hit, clock, reset, rsp_no_hit |-> (rsp_depth_ff == '0))
   `ZB_ASSERT_NEVER(a_write_owner, clock, reset, mem_we && (state_ff == ST_IDLE || state_ff == ST_PROJ))
endmodule
`default_nettype wire
